/* src/markup_text_content_tokenizer_top_assert.svh */
// Assertion macros for the tokenizer. Synthesis builds define SYNTH and get empty bodies.
`ifndef MARKUP_TEXT_CONTENT_TOKENIZER_TOP_ASSERT_SVH
`define MARKUP_TEXT_CONTENT_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define MTCT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");
// Next-cycle implication, disabled while reset is high.
`define MTCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");
`else
`define MTCT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MTCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/mtct_pkg.sv */
package mtct_pkg;

   // Field widths.
   localparam int TEXT_BYTE_W    = 8;
   localparam int TOKEN_LENGTH_W = 13;
   localparam int CHUNK_MODE_W   = 2;

   // Defaults for the top-level parameters.
   localparam int MAX_TOKEN_LENGTH_DEF   = 4096;
   localparam int ITEM_QUEUE_DEPTH_DEF   = 4;
   localparam int RESULT_QUEUE_DEPTH_DEF = 4;

   // Configuration port geometry.
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_INDEX_W = CSR_ADDR_W - 2;

   // Register reset values.
   localparam logic [CHUNK_MODE_W-1:0] CHUNK_MODE_RST = 2'd1;
   localparam logic ENTITY_ENABLE_RST = 1'b1;
   localparam logic LBRACE_ESC_RST    = 1'b1;
   localparam logic RBRACE_ESC_RST    = 1'b1;
   localparam logic AT_ESC_RST        = 1'b0;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_CHUNK_MODE    = 3'd0,
      REG_ENTITY_ENABLE = 3'd1,
      REG_LBRACE_ESC    = 3'd2,
      REG_RBRACE_ESC    = 3'd3,
      REG_AT_ESC        = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      KIND_TEXT    = 3'd0,
      KIND_EMBED   = 3'd1,
      KIND_ENTITY  = 3'd2,
      KIND_LBRACE  = 3'd3,
      KIND_RBRACE  = 3'd4,
      KIND_AT      = 3'd5,
      KIND_STOP    = 3'd6
   } token_kind_type;

   // Character codes the scanner cares about.
   localparam logic [TEXT_BYTE_W-1:0] CH_NUL     = 8'h00;
   localparam logic [TEXT_BYTE_W-1:0] CH_HASH    = 8'h23;
   localparam logic [TEXT_BYTE_W-1:0] CH_AMP     = 8'h26;
   localparam logic [TEXT_BYTE_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [TEXT_BYTE_W-1:0] CH_LT      = 8'h3C;
   localparam logic [TEXT_BYTE_W-1:0] CH_AT      = 8'h40;
   localparam logic [TEXT_BYTE_W-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [TEXT_BYTE_W-1:0] CH_LBRACE  = 8'h7B;
   localparam logic [TEXT_BYTE_W-1:0] CH_RBRACE  = 8'h7D;
   localparam logic [TEXT_BYTE_W-1:0] CH_X_UPPER = 8'h58;
   localparam logic [TEXT_BYTE_W-1:0] CH_X_LOWER = 8'h78;
   localparam logic [TEXT_BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [TEXT_BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [TEXT_BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [TEXT_BYTE_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [TEXT_BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [TEXT_BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [TEXT_BYTE_W-1:0] CH_LOWER_F = 8'h66;
   localparam logic [TEXT_BYTE_W-1:0] CH_LOWER_Z = 8'h7A;

   typedef struct packed {
      logic is_zero;
      logic is_lt;
      logic is_lbrace;
      logic is_rbrace;
      logic is_at;
      logic is_bslash;
      logic is_amp;
      logic is_hash;
      logic is_semi;
      logic is_x;
      logic is_digit;
      logic is_alpha;
      logic is_hex;
   } char_class_type;

   typedef struct packed {
      logic           region_start;
      logic           region_end;
      char_class_type cls;
   } scan_item_type;

   typedef struct packed {
      token_kind_type             kind;
      logic [TOKEN_LENGTH_W-1:0]  length;
      logic                       last;
   } result_type;

   typedef struct packed {
      logic [CHUNK_MODE_W-1:0] chunk_mode;
      logic                    entity_enable;
      logic                    lbrace_escape_enable;
      logic                    rbrace_escape_enable;
      logic                    at_escape_enable;
   } cfg_type;

   // Sort one byte into the classes the scanner tests.
   function automatic char_class_type classify(input logic [TEXT_BYTE_W-1:0] c);
      char_class_type r;
      logic upper_hex;
      logic lower_hex;
      r.is_zero   = (c == CH_NUL);
      r.is_lt     = (c == CH_LT);
      r.is_lbrace = (c == CH_LBRACE);
      r.is_rbrace = (c == CH_RBRACE);
      r.is_at     = (c == CH_AT);
      r.is_bslash = (c == CH_BSLASH);
      r.is_amp    = (c == CH_AMP);
      r.is_hash   = (c == CH_HASH);
      r.is_semi   = (c == CH_SEMI);
      r.is_x      = (c == CH_X_UPPER) || (c == CH_X_LOWER);
      r.is_digit  = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
      r.is_alpha  = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
                    ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
      upper_hex   = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
      lower_hex   = (c >= CH_LOWER_A) && (c <= CH_LOWER_F);
      r.is_hex    = r.is_digit || upper_hex || lower_hex;
      return r;
   endfunction

endpackage

/* src/mtct_queue.sv */
module mtct_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(1);
   localparam logic [PTR_W-1:0] ONE_PTR = PTR_W'(1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointers wrap at the last slot, so any depth works.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + ONE_PTR;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + ONE_PTR;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + ONE_COUNT;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - ONE_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/mtct_front.sv */
module mtct_front (
   input  logic                                push,
   output logic                                full,
   input  logic [mtct_pkg::TEXT_BYTE_W-1:0]    text_byte,
   input  logic                                region_start,
   input  logic                                region_end,
   output logic                                q_push,
   output mtct_pkg::scan_item_type             q_data,
   input  logic                                q_full
);

   // A beat is taken whenever the item queue has room; the byte is
   // reduced to the classes the scanner needs before it is queued.
   assign full                = q_full;
   assign q_push              = push;
   assign q_data.region_start = region_start;
   assign q_data.region_end   = region_end;
   assign q_data.cls          = mtct_pkg::classify(text_byte);

endmodule

/* src/mtct_csr.sv */
module mtct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mtct_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mtct_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mtct_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output mtct_pkg::cfg_type                   cfg
);

   logic [mtct_pkg::CHUNK_MODE_W-1:0] chunk_mode_ff;
   logic                              entity_enable_ff;
   logic                              lbrace_esc_ff;
   logic                              rbrace_esc_ff;
   logic                              at_esc_ff;
   logic [mtct_pkg::REG_INDEX_W-1:0]  reg_index;
   logic                              wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[mtct_pkg::CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;

   // Register writes land in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_mode_ff    <= mtct_pkg::CHUNK_MODE_RST;
         entity_enable_ff <= mtct_pkg::ENTITY_ENABLE_RST;
         lbrace_esc_ff    <= mtct_pkg::LBRACE_ESC_RST;
         rbrace_esc_ff    <= mtct_pkg::RBRACE_ESC_RST;
         at_esc_ff        <= mtct_pkg::AT_ESC_RST;
      end else if (wr_en) begin
         case (reg_index)
            mtct_pkg::REG_CHUNK_MODE: begin
               chunk_mode_ff <= pwdata[mtct_pkg::CHUNK_MODE_W-1:0];
            end
            mtct_pkg::REG_ENTITY_ENABLE: begin
               entity_enable_ff <= pwdata[0];
            end
            mtct_pkg::REG_LBRACE_ESC: begin
               lbrace_esc_ff <= pwdata[0];
            end
            mtct_pkg::REG_RBRACE_ESC: begin
               rbrace_esc_ff <= pwdata[0];
            end
            mtct_pkg::REG_AT_ESC: begin
               at_esc_ff <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read-back of the register at the addressed slot.
   always_comb begin
      prdata = '0;
      case (reg_index)
         mtct_pkg::REG_CHUNK_MODE: begin
            prdata[mtct_pkg::CHUNK_MODE_W-1:0] = chunk_mode_ff;
         end
         mtct_pkg::REG_ENTITY_ENABLE: begin
            prdata[0] = entity_enable_ff;
         end
         mtct_pkg::REG_LBRACE_ESC: begin
            prdata[0] = lbrace_esc_ff;
         end
         mtct_pkg::REG_RBRACE_ESC: begin
            prdata[0] = rbrace_esc_ff;
         end
         mtct_pkg::REG_AT_ESC: begin
            prdata[0] = at_esc_ff;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.chunk_mode           = chunk_mode_ff;
   assign cfg.entity_enable        = entity_enable_ff;
   assign cfg.lbrace_escape_enable = lbrace_esc_ff;
   assign cfg.rbrace_escape_enable = rbrace_esc_ff;
   assign cfg.at_escape_enable     = at_esc_ff;

endmodule

/* src/mtct_back.sv */
module mtct_back #(
   parameter int MAX_TOKEN_LENGTH = mtct_pkg::MAX_TOKEN_LENGTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mtct_pkg::cfg_type       cfg,
   input  logic                    item_valid,
   input  mtct_pkg::scan_item_type item,
   output logic                    item_pop,
   output logic                    res_push,
   output mtct_pkg::result_type    res_data,
   input  logic                    res_full
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam int LW = (LEN_W > mtct_pkg::TOKEN_LENGTH_W) ? LEN_W : mtct_pkg::TOKEN_LENGTH_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LENGTH);
   localparam logic [LW-1:0] LEN_ONE = LW'(1);
   localparam logic [LW-1:0] LEN_TWO = LW'(2);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_ESC,
      PH_AMP,
      PH_HASH,
      PH_X,
      PH_HEX,
      PH_DEC,
      PH_NAME,
      PH_CHUNK,
      PH_CH_AT,
      PH_CH_BS,
      PH_STOP_PEND
   } phase_type;

   phase_type                phase_ff, phase_in, phase_cur;
   logic [LW-1:0]            pend_ff, pend_in, pend_cur;
   logic [LW-1:0]            mark_ff, mark_in, mark_cur;
   logic                     content_ff, content_in, content_cur;
   logic                     first_ff, first_in;
   logic                     zero_pass_ff, zero_pass_in;
   logic                     held_valid_ff;
   logic                     held_final_ff;
   mtct_pkg::token_kind_type held_kind_ff;
   logic [LW-1:0]            held_len_ff;

   mtct_pkg::char_class_type cls;
   mtct_pkg::token_kind_type chunk_kind;
   mtct_pkg::token_kind_type f_kind;
   logic [LW-1:0]            f_len;
   logic                     f_emit;
   logic                     f_done;
   logic                     do_stop, do_fail, do_split, do_restart, do_restart_tail;
   logic                     chunks_on, embed_on, at_max, run_cont;
   logic                     skip, emit, item_done, want_push, fire;

   // A region start drops any token under way before the byte is scanned.
   always_comb begin
      if (first_ff && item.region_start) begin
         phase_cur   = PH_START;
         pend_cur    = '0;
         mark_cur    = '0;
         content_cur = 1'b0;
      end else begin
         phase_cur   = phase_ff;
         pend_cur    = pend_ff;
         mark_cur    = mark_ff;
         content_cur = content_ff;
      end
   end

   // The end-of-text pass scans a zero byte after the real one.
   assign cls        = zero_pass_ff ? mtct_pkg::classify(mtct_pkg::CH_NUL) : item.cls;
   assign chunks_on  = (cfg.chunk_mode != '0);
   assign embed_on   = cfg.chunk_mode[1];
   assign chunk_kind = embed_on ? mtct_pkg::KIND_EMBED : mtct_pkg::KIND_TEXT;
   assign at_max     = (pend_cur >= MAX_LEN);

   // Which bytes keep an entity body going.
   always_comb begin
      case (phase_cur)
         PH_HEX:  run_cont = cls.is_hex;
         PH_DEC:  run_cont = cls.is_digit;
         default: run_cont = cls.is_alpha || cls.is_digit;
      endcase
   end

   // One scanner step. f_done low means the same byte is scanned again.
   always_comb begin
      phase_in        = phase_cur;
      pend_in         = pend_cur;
      mark_in         = mark_cur;
      content_in      = content_cur;
      f_emit          = 1'b0;
      f_kind          = mtct_pkg::KIND_TEXT;
      f_len           = '0;
      f_done          = 1'b1;
      do_stop         = 1'b0;
      do_fail         = 1'b0;
      do_split        = 1'b0;
      do_restart      = 1'b0;
      do_restart_tail = 1'b0;
      case (phase_cur)
         PH_START: begin
            if (cls.is_bslash) begin
               pend_in  = LEN_ONE;
               phase_in = PH_ESC;
            end else if (cls.is_amp && cfg.entity_enable) begin
               pend_in  = LEN_ONE;
               phase_in = PH_AMP;
            end else if (!chunks_on) begin
               do_stop = 1'b1;
            end else begin
               content_in = 1'b0;
               mark_in    = '0;
               pend_in    = '0;
               phase_in   = PH_CHUNK;
               f_done     = 1'b0;
            end
         end
         PH_ESC: begin
            if (cls.is_lbrace) begin
               if (!cfg.lbrace_escape_enable) begin
                  do_stop = 1'b1;
               end else begin
                  f_emit     = 1'b1;
                  f_kind     = mtct_pkg::KIND_LBRACE;
                  f_len      = LEN_TWO;
                  do_restart = 1'b1;
               end
            end else if (cls.is_rbrace) begin
               if (!cfg.rbrace_escape_enable) begin
                  do_stop = 1'b1;
               end else begin
                  f_emit     = 1'b1;
                  f_kind     = mtct_pkg::KIND_RBRACE;
                  f_len      = LEN_TWO;
                  do_restart = 1'b1;
               end
            end else if (cls.is_at && cfg.at_escape_enable) begin
               f_emit     = 1'b1;
               f_kind     = mtct_pkg::KIND_AT;
               f_len      = LEN_TWO;
               do_restart = 1'b1;
            end else if (!chunks_on) begin
               do_stop = 1'b1;
            end else begin
               // A lone backslash is text of its own; rescan the byte.
               f_emit     = 1'b1;
               f_kind     = chunk_kind;
               f_len      = LEN_ONE;
               do_restart = 1'b1;
               f_done     = 1'b0;
            end
         end
         PH_AMP: begin
            if (cls.is_hash || cls.is_alpha) begin
               if (at_max) begin
                  do_fail = 1'b1;
               end else begin
                  pend_in  = pend_cur + LEN_ONE;
                  phase_in = cls.is_hash ? PH_HASH : PH_NAME;
               end
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_HASH: begin
            if (at_max) begin
               do_fail = 1'b1;
            end else if (cls.is_x) begin
               pend_in  = pend_cur + LEN_ONE;
               phase_in = PH_X;
            end else if (cls.is_digit) begin
               pend_in  = pend_cur + LEN_ONE;
               phase_in = PH_DEC;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_X: begin
            if (at_max || !cls.is_hex) begin
               do_fail = 1'b1;
            end else begin
               pend_in  = pend_cur + LEN_ONE;
               phase_in = PH_HEX;
            end
         end
         PH_HEX, PH_DEC, PH_NAME: begin
            if (at_max) begin
               do_fail = 1'b1;
            end else if (run_cont) begin
               pend_in = pend_cur + LEN_ONE;
            end else if (cls.is_semi) begin
               f_emit     = 1'b1;
               f_kind     = mtct_pkg::KIND_ENTITY;
               f_len      = pend_cur + LEN_ONE;
               do_restart = 1'b1;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_CHUNK: begin
            if (cls.is_zero || cls.is_lt || cls.is_lbrace || cls.is_rbrace) begin
               if (!content_cur) begin
                  do_stop = 1'b1;
               end else begin
                  do_split = 1'b1;
               end
            end else if ((embed_on && cls.is_at) || cls.is_bslash) begin
               // The chunk is certain up to here; the marker may still join it.
               mark_in = pend_cur;
               if (at_max) begin
                  do_split = 1'b1;
               end else begin
                  pend_in  = pend_cur + LEN_ONE;
                  phase_in = cls.is_bslash ? PH_CH_BS : PH_CH_AT;
               end
            end else if (cls.is_amp && cfg.entity_enable && content_cur) begin
               mark_in  = pend_cur;
               do_split = 1'b1;
            end else if (at_max) begin
               do_split = 1'b1;
            end else begin
               pend_in    = pend_cur + LEN_ONE;
               mark_in    = pend_cur + LEN_ONE;
               content_in = 1'b1;
            end
         end
         PH_CH_AT: begin
            if (cls.is_lbrace) begin
               if (content_cur) begin
                  // Chunk first, the stop follows in the next step.
                  f_emit   = 1'b1;
                  f_kind   = chunk_kind;
                  f_len    = mark_cur;
                  phase_in = PH_STOP_PEND;
                  f_done   = 1'b0;
               end else begin
                  do_stop = 1'b1;
               end
            end else begin
               content_in = 1'b1;
               mark_in    = pend_cur;
               phase_in   = PH_CHUNK;
               f_done     = 1'b0;
            end
         end
         PH_CH_BS: begin
            if (cls.is_lbrace || cls.is_rbrace || (embed_on && cls.is_at)) begin
               if (!content_cur) begin
                  do_stop = 1'b1;
               end else begin
                  f_emit          = 1'b1;
                  f_kind          = chunk_kind;
                  f_len           = mark_cur;
                  do_restart_tail = 1'b1;
                  f_done          = 1'b0;
               end
            end else begin
               content_in = 1'b1;
               phase_in   = PH_CHUNK;
               f_done     = 1'b0;
            end
         end
         PH_STOP_PEND: begin
            do_stop = 1'b1;
         end
         default: begin
         end
      endcase

      // Report the certain part of a chunk; an uncertain backslash starts the next token.
      if (do_split) begin
         f_emit = 1'b1;
         f_kind = chunk_kind;
         f_len  = mark_in;
         f_done = 1'b0;
         if (pend_in != mark_in) begin
            do_restart_tail = 1'b1;
         end else begin
            do_restart = 1'b1;
         end
      end
      // A failed entity turns into chunk text, or ends the region.
      if (do_fail) begin
         if (!chunks_on) begin
            do_stop = 1'b1;
         end else begin
            content_in = 1'b1;
            mark_in    = pend_cur;
            phase_in   = PH_CHUNK;
            f_done     = 1'b0;
         end
      end
      if (do_restart) begin
         content_in = 1'b0;
         mark_in    = '0;
         pend_in    = '0;
         phase_in   = PH_START;
      end
      if (do_restart_tail) begin
         content_in = 1'b0;
         mark_in    = '0;
         pend_in    = LEN_ONE;
         phase_in   = PH_ESC;
      end
      if (do_stop) begin
         f_emit     = 1'b1;
         f_kind     = mtct_pkg::KIND_STOP;
         f_len      = '0;
         f_done     = 1'b1;
         content_in = 1'b0;
         mark_in    = '0;
         pend_in    = '0;
         phase_in   = PH_IDLE;
      end
   end

   // Item sequencing: an idle scanner drops the byte, region end adds a zero-byte pass.
   assign skip      = (phase_cur == PH_IDLE);
   assign emit      = item_valid && !skip && f_emit;
   assign item_done = skip || (f_done &&
                      !(!zero_pass_ff && item.region_end && (phase_in != PH_IDLE)));
   assign first_in     = item_done;
   assign zero_pass_in = !item_done && (zero_pass_ff || f_done);

   // The newest result is held back until it is known whether it closes the beat's run.
   assign want_push = held_valid_ff &&
                      (held_final_ff || (item_valid && (emit || item_done)));
   assign fire      = item_valid && !(want_push && res_full);
   assign res_push  = want_push && !res_full;
   assign item_pop  = fire && item_done;

   assign res_data.kind   = held_kind_ff;
   assign res_data.length = held_len_ff[mtct_pkg::TOKEN_LENGTH_W-1:0];
   assign res_data.last   = held_final_ff || !emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         pend_ff       <= '0;
         mark_ff       <= '0;
         content_ff    <= 1'b0;
         first_ff      <= 1'b1;
         zero_pass_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         held_final_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff     <= phase_in;
            pend_ff      <= pend_in;
            mark_ff      <= mark_in;
            content_ff   <= content_in;
            first_ff     <= first_in;
            zero_pass_ff <= zero_pass_in;
         end
         if (fire && emit) begin
            held_valid_ff <= 1'b1;
            held_final_ff <= item_done;
            held_kind_ff  <= f_kind;
            held_len_ff   <= f_len;
         end else if (res_push) begin
            held_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* src/markup_text_content_tokenizer_top.sv */
// Channel   Handshake            Beat contents
// -------   ------------------   ------------------------------------------------
// request   push / full          req_text_byte, req_region_start, req_region_end
// response  pop / empty          rsp_token_kind, rsp_token_length, rsp_last_of_run
// config    psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// The scanner takes one step per cycle while an item is queued and no full response
// queue holds it: a byte that opens or ends a chunk or breaks an entity is scanned
// again, and region end adds the steps of the trailing zero-byte scan.
// Reset is synchronous; queues come up empty and the scanner waits for a region start.
// Request beats queue up while the scanner works; the scanner stalls only when
// the response queue is full, and request beats stall only when the item queue is.

`include "markup_text_content_tokenizer_top_assert.svh"

module markup_text_content_tokenizer_top #(
   parameter int MAX_TOKEN_LENGTH   = mtct_pkg::MAX_TOKEN_LENGTH_DEF,
   parameter int ITEM_QUEUE_DEPTH   = mtct_pkg::ITEM_QUEUE_DEPTH_DEF,
   parameter int RESULT_QUEUE_DEPTH = mtct_pkg::RESULT_QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [mtct_pkg::TEXT_BYTE_W-1:0]      req_text_byte,
   input  logic                                  req_region_start,
   input  logic                                  req_region_end,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [2:0]                            rsp_token_kind,
   output logic [mtct_pkg::TOKEN_LENGTH_W-1:0]   rsp_token_length,
   output logic                                  rsp_last_of_run,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mtct_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [mtct_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [mtct_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int ITEM_W   = $bits(mtct_pkg::scan_item_type);
   localparam int RESULT_W = $bits(mtct_pkg::result_type);

   mtct_pkg::cfg_type       cfg;
   mtct_pkg::scan_item_type front_data;
   mtct_pkg::scan_item_type item_head;
   mtct_pkg::result_type    res_data;
   mtct_pkg::result_type    res_head;
   logic                    front_push;
   logic                    item_full;
   logic                    item_empty;
   logic                    item_valid;
   logic                    item_pop;
   logic                    res_push;
   logic                    res_full;

   // Configuration registers.
   mtct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Front end: accept and classify request beats.
   mtct_front u_front (
      .push         (push),
      .full         (full),
      .text_byte    (req_text_byte),
      .region_start (req_region_start),
      .region_end   (req_region_end),
      .q_push       (front_push),
      .q_data       (front_data),
      .q_full       (item_full)
   );

   // Queue between the front end and the scanner.
   mtct_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (ITEM_QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (item_head),
      .empty     (item_empty)
   );

   assign item_valid = !item_empty;

   // Scanner.
   mtct_back #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item_head),
      .item_pop   (item_pop),
      .res_push   (res_push),
      .res_data   (res_data),
      .res_full   (res_full)
   );

   // Response queue feeding the result ports.
   mtct_queue #(
      .WIDTH (RESULT_W),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_head),
      .empty     (empty)
   );

   assign rsp_token_kind   = res_head.kind;
   assign rsp_token_length = res_head.length;
   assign rsp_last_of_run  = res_head.last;

   // The scanner never writes a full response queue.
   `MTCT_ASSERT_IMPLIES(a_res_no_overflow, clock, reset, res_push, !res_full)
   // An item leaves the queue only while one is there.
   `MTCT_ASSERT_IMPLIES(a_item_pop_valid, clock, reset, item_pop, item_valid)
   // A stop always closes its run and carries no length.
   `MTCT_ASSERT_IMPLIES(a_stop_is_last, clock, reset,
      !empty && (rsp_token_kind == mtct_pkg::KIND_STOP),
      rsp_last_of_run && (rsp_token_length == '0))
   // A pushed result is visible on the next cycle.
   `MTCT_ASSERT_NEXT(a_push_shows, clock, reset, res_push, !empty)

endmodule

/* verif/tokenizer_checker.sv */
module tokenizer_checker
   import mtct_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      full,
   input  logic [TEXT_BYTE_W-1:0]    req_text_byte,
   input  logic                      req_region_start,
   input  logic                      req_region_end,
   input  logic                      pop,
   input  logic                      empty,
   input  logic [2:0]                rsp_token_kind,
   input  logic [TOKEN_LENGTH_W-1:0] rsp_token_length,
   input  logic                      rsp_last_of_run,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   input  logic [CSR_DATA_W-1:0]     prdata,
   input  logic                      pready,
   output int                        error_count,
   output int                        pending_tokens,
   output int                        tokens_checked
);

   typedef enum logic [3:0] {
      SC_IDLE, SC_START, SC_ESC, SC_AMP, SC_HASH, SC_X, SC_HEX, SC_DEC, SC_NAME,
      SC_CHUNK, SC_CH_AT, SC_CH_BS
   } scan_phase_t;

   typedef struct packed {
      token_kind_type            kind;
      logic [TOKEN_LENGTH_W-1:0] length;
      logic                      last;
   } token_beat_t;

   // Scanner state and register copy kept by the predictor.
   scan_phase_t  phase;
   int unsigned  taken_len;
   int unsigned  sure_len;
   bit           in_text;
   logic [1:0]   mode_reg;
   bit           ent_en;
   bit           lb_en;
   bit           rb_en;
   bit           at_en;

   token_beat_t  step_tokens[$];
   token_beat_t  due_tokens[$];

   function automatic bit digit_char(input logic [7:0] c);
      return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
   endfunction

   function automatic bit letter_char(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic bit hex_char(input logic [7:0] c);
      return digit_char(c) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
   endfunction

   function automatic token_kind_type text_kind();
      return mode_reg[1] ? KIND_EMBED : KIND_TEXT;
   endfunction

   // A single byte never yields more than four tokens; extra ones are lost.
   function automatic void put_token(input token_kind_type k, input int unsigned n);
      token_beat_t t;
      if (step_tokens.size() < 4) begin
         t.kind   = k;
         t.length = n[TOKEN_LENGTH_W-1:0];
         t.last   = 1'b0;
         step_tokens.push_back(t);
      end
   endfunction

   // Open a new token; with a carried backslash it becomes the first byte.
   function automatic void begin_token(input bit tail);
      in_text   = 1'b0;
      sure_len  = 0;
      taken_len = tail ? 1 : 0;
      phase     = tail ? SC_ESC : SC_START;
   endfunction

   function automatic bit halt_scan();
      put_token(KIND_STOP, 0);
      phase     = SC_IDLE;
      taken_len = 0;
      sure_len  = 0;
      in_text   = 1'b0;
      return 1'b1;
   endfunction

   // A broken entity turns into chunk text, or stops when chunks are off.
   function automatic bit entity_to_text();
      if (mode_reg == 2'd0) return halt_scan();
      in_text  = 1'b1;
      sure_len = taken_len;
      phase    = SC_CHUNK;
      return 1'b0;
   endfunction

   function automatic bit entity_body(input logic [7:0] c, input bit cont);
      if (taken_len >= MAX_TOKEN_LENGTH) return entity_to_text();
      if (cont) begin
         taken_len++;
         return 1'b1;
      end
      if (c == CH_SEMI) begin
         put_token(KIND_ENTITY, taken_len + 1);
         begin_token(1'b0);
         return 1'b1;
      end
      return entity_to_text();
   endfunction

   function automatic bit cut_chunk();
      bit tail;
      tail = (taken_len != sure_len);
      put_token(text_kind(), sure_len);
      begin_token(tail);
      return 1'b0;
   endfunction

   // One scanner pass over a byte; a zero return means the byte is scanned again.
   function automatic bit scan_once(input logic [7:0] c);
      case (phase)
         SC_START: begin
            if (c == CH_BSLASH) begin
               taken_len = 1;
               phase     = SC_ESC;
               return 1'b1;
            end
            if (c == CH_AMP && ent_en) begin
               taken_len = 1;
               phase     = SC_AMP;
               return 1'b1;
            end
            if (mode_reg == 2'd0) return halt_scan();
            begin_token(1'b0);
            phase = SC_CHUNK;
            return 1'b0;
         end
         SC_ESC: begin
            if (c == CH_LBRACE) begin
               if (!lb_en) return halt_scan();
               put_token(KIND_LBRACE, 2);
               begin_token(1'b0);
               return 1'b1;
            end
            if (c == CH_RBRACE) begin
               if (!rb_en) return halt_scan();
               put_token(KIND_RBRACE, 2);
               begin_token(1'b0);
               return 1'b1;
            end
            if (c == CH_AT && at_en) begin
               put_token(KIND_AT, 2);
               begin_token(1'b0);
               return 1'b1;
            end
            if (mode_reg == 2'd0) return halt_scan();
            put_token(text_kind(), 1);
            begin_token(1'b0);
            return 1'b0;
         end
         SC_AMP: begin
            if (c == CH_HASH || letter_char(c)) begin
               if (taken_len >= MAX_TOKEN_LENGTH) return entity_to_text();
               taken_len++;
               phase = (c == CH_HASH) ? SC_HASH : SC_NAME;
               return 1'b1;
            end
            return entity_to_text();
         end
         SC_HASH: begin
            if (taken_len >= MAX_TOKEN_LENGTH) return entity_to_text();
            if (c == CH_X_LOWER || c == CH_X_UPPER || digit_char(c)) begin
               taken_len++;
               phase = digit_char(c) ? SC_DEC : SC_X;
               return 1'b1;
            end
            return entity_to_text();
         end
         SC_X: begin
            if (taken_len >= MAX_TOKEN_LENGTH || !hex_char(c)) return entity_to_text();
            taken_len++;
            phase = SC_HEX;
            return 1'b1;
         end
         SC_HEX:  return entity_body(c, hex_char(c));
         SC_DEC:  return entity_body(c, digit_char(c));
         SC_NAME: return entity_body(c, letter_char(c) || digit_char(c));
         SC_CHUNK: begin
            if (c == CH_NUL || c == CH_LT || c == CH_LBRACE || c == CH_RBRACE) begin
               if (!in_text) return halt_scan();
               return cut_chunk();
            end
            if ((mode_reg[1] && c == CH_AT) || c == CH_BSLASH) begin
               sure_len = taken_len;
               if (taken_len >= MAX_TOKEN_LENGTH) return cut_chunk();
               taken_len++;
               phase = (c == CH_AT) ? SC_CH_AT : SC_CH_BS;
               return 1'b1;
            end
            if (c == CH_AMP && ent_en && in_text) begin
               sure_len = taken_len;
               return cut_chunk();
            end
            if (taken_len >= MAX_TOKEN_LENGTH) return cut_chunk();
            taken_len++;
            sure_len = taken_len;
            in_text  = 1'b1;
            return 1'b1;
         end
         SC_CH_AT: begin
            // An at-sign followed by a left brace closes the text region.
            if (c == CH_LBRACE) begin
               if (in_text) put_token(text_kind(), sure_len);
               return halt_scan();
            end
            in_text  = 1'b1;
            sure_len = taken_len;
            phase    = SC_CHUNK;
            return 1'b0;
         end
         SC_CH_BS: begin
            if (c == CH_LBRACE || c == CH_RBRACE || (mode_reg[1] && c == CH_AT)) begin
               if (!in_text) return halt_scan();
               put_token(text_kind(), sure_len);
               begin_token(1'b1);
               return 1'b0;
            end
            in_text = 1'b1;
            phase   = SC_CHUNK;
            return 1'b0;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic void scan_byte(input logic [7:0] c);
      int guard;
      guard = 0;
      while (!scan_once(c) && guard < 16) guard++;
   endfunction

   // Work out the tokens one request beat causes and queue them as due.
   function automatic void predict_tokens(input logic [7:0] c, input bit s, input bit e);
      step_tokens.delete();
      if (s) begin_token(1'b0);
      if (phase != SC_IDLE) scan_byte(c);
      if (e && phase != SC_IDLE) scan_byte(CH_NUL);
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("check_tokens: %s", msg);
   endtask

   // Watch all three ports at each rising edge. Results are compared before the
   // request of the same edge is predicted, since it cannot have a result yet.
   always @(posedge clock) begin
      token_beat_t                 want;
      logic [CSR_DATA_W-1:0]       want_reg;
      reg_index_type               idx;
      if (reset) begin
         phase          = SC_IDLE;
         taken_len      = 0;
         sure_len       = 0;
         in_text        = 1'b0;
         mode_reg       = CHUNK_MODE_RST;
         ent_en         = ENTITY_ENABLE_RST;
         lb_en          = LBRACE_ESC_RST;
         rb_en          = RBRACE_ESC_RST;
         at_en          = AT_ESC_RST;
         error_count    = 0;
         tokens_checked = 0;
         due_tokens.delete();
      end else begin
         if (pop && !empty) begin
            if (due_tokens.size() == 0) begin
               note_error($sformatf("token beat with nothing due: kind %0d length %0d",
                                    rsp_token_kind, rsp_token_length));
            end else begin
               want = due_tokens.pop_front();
               tokens_checked++;
               if (rsp_token_kind !== want.kind)
                  note_error($sformatf("kind expected %0d, got %0d",
                                       want.kind, rsp_token_kind));
               if (rsp_token_length !== want.length)
                  note_error($sformatf("length expected %0d, got %0d",
                                       want.length, rsp_token_length));
               if (rsp_last_of_run !== want.last)
                  note_error($sformatf("last_of_run expected %0d, got %0d",
                                       want.last, rsp_last_of_run));
            end
         end
         if (push && !full) predict_tokens(req_text_byte, req_region_start, req_region_end);
         if (psel && penable && pready) begin
            idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
            if (pwrite) begin
               case (idx)
                  REG_CHUNK_MODE:    mode_reg = pwdata[1:0];
                  REG_ENTITY_ENABLE: ent_en   = pwdata[0];
                  REG_LBRACE_ESC:    lb_en    = pwdata[0];
                  REG_RBRACE_ESC:    rb_en    = pwdata[0];
                  REG_AT_ESC:        at_en    = pwdata[0];
                  default: ;
               endcase
            end else begin
               case (idx)
                  REG_CHUNK_MODE:    want_reg = CSR_DATA_W'(mode_reg);
                  REG_ENTITY_ENABLE: want_reg = CSR_DATA_W'(ent_en);
                  REG_LBRACE_ESC:    want_reg = CSR_DATA_W'(lb_en);
                  REG_RBRACE_ESC:    want_reg = CSR_DATA_W'(rb_en);
                  REG_AT_ESC:        want_reg = CSR_DATA_W'(at_en);
                  default:           want_reg = prdata;
               endcase
               if (prdata !== want_reg)
                  note_error($sformatf("register %0d read expected %0h, got %0h",
                                       idx, want_reg, prdata));
            end
         end
      end
      pending_tokens = due_tokens.size();
   end

endmodule

/* verif/tb.sv */
module tb;
   import mtct_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic [TEXT_BYTE_W-1:0]    req_text_byte;
   logic                      req_region_start;
   logic                      req_region_end;
   logic                      empty;
   logic                      pop;
   logic [2:0]                rsp_token_kind;
   logic [TOKEN_LENGTH_W-1:0] rsp_token_length;
   logic                      rsp_last_of_run;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   int         error_count;
   int         pending_tokens;
   int         tokens_checked;
   bit         steady;
   int         beats_sent;
   int         settings_applied;
   logic [7:0] run_q[$];

   markup_text_content_tokenizer_top dut (.*);

   tokenizer_checker check_tokens (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result side: pop at random, or on every cycle during the steady stretch.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= steady || ($urandom_range(99) >= 29);
      end
   end

   // Send one request beat after a random idle gap and wait until it is taken.
   task automatic send_beat(input logic [7:0] b, input bit s, input bit e);
      while (!steady && $urandom_range(99) < 29) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_text_byte    <= b;
      req_region_start <= s;
      req_region_end   <= e;
      do @(posedge clock); while (full);
   endtask

   // Send the bytes gathered in run_q as one stretch of text.
   task automatic send_run(input bit start_flag, input bit end_flag);
      foreach (run_q[i]) begin
         send_beat(run_q[i], start_flag && i == 0, end_flag && i == run_q.size() - 1);
         beats_sent++;
      end
      run_q.delete();
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) run_q.push_back(s[i]);
   endtask

   // Let every due token drain, then give the scanner time to finish silent work.
   task automatic settle();
      int waited;
      push <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_tokens != 0 && waited < 200000);
      repeat (64) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input bit wr, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a full register setting while the block is idle, then read it back.
   task automatic apply_setting(input logic [1:0] m, input bit e, input bit l, input bit r,
                                input bit a);
      settle();
      csr_access(REG_CHUNK_MODE, 1'b1, 32'(m));
      csr_access(REG_ENTITY_ENABLE, 1'b1, 32'(e));
      csr_access(REG_LBRACE_ESC, 1'b1, 32'(l));
      csr_access(REG_RBRACE_ESC, 1'b1, 32'(r));
      csr_access(REG_AT_ESC, 1'b1, 32'(a));
      for (int k = 0; k <= 4; k++) csr_access(reg_index_type'(k), 1'b0, 32'd0);
      settings_applied++;
   endtask

   initial begin
      int    phase_no;
      int    goal;
      string word_chars;
      string name_chars;
      string hex_chars;
      string esc_tail;
      string stops;
      word_chars = "hello WORLD 0129 xyz.,!?-";
      name_chars = "abcdefxyzABCDFXZ";
      hex_chars  = "0189aAfF";
      esc_tail   = "{}@a&\\";
      stops      = "<{}";
      push             <= 1'b0;
      pop              <= 1'b0;
      req_text_byte    <= '0;
      req_region_start <= 1'b0;
      req_region_end   <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      reset            <= 1'b1;
      steady           = 1'b0;
      beats_sent       = 0;
      settings_applied = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset setting: a byte while idle, the text, entity, brace and
      // stop kinds, a broken entity, the byte extremes, a start inside a token and a lone beat.
      send_beat("z", 1'b0, 1'b0);
      append_text("a&amp;\\{\\}");
      send_run(1'b1, 1'b0);
      append_text("&#x1F;&#9;&<");
      send_run(1'b0, 1'b1);
      run_q.push_back(8'hFF);
      append_text("m");
      run_q.push_back(CH_NUL);
      send_run(1'b1, 1'b0);
      append_text("&a");
      send_run(1'b1, 1'b0);
      append_text("\\@x");
      send_run(1'b1, 1'b1);
      append_text("k");
      send_run(1'b1, 1'b1);

      // Over-long chunk and entity: the chunk is cut at the maximum token length, the entity turns into chunk text.
      repeat (MAX_TOKEN_LENGTH_DEF + 4) run_q.push_back("a");
      append_text("<");
      send_run(1'b1, 1'b0);
      append_text("&");
      repeat (MAX_TOKEN_LENGTH_DEF + 4) run_q.push_back("b");
      append_text(";");
      send_run(1'b1, 1'b1);

      // Random part: mostly well-formed regions built from token pieces, some noise.
      for (phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: apply_setting(2'd2, 1'b1, 1'b1, 1'b1, 1'b1);
            1: apply_setting(2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            2: apply_setting(2'd3, 1'b1, 1'b0, 1'b1, 1'b1);
            3: apply_setting(2'd1, 1'b0, 1'b1, 1'b0, 1'b1);
            default: apply_setting($urandom_range(3), $urandom_range(1), $urandom_range(1),
                                   $urandom_range(1), $urandom_range(1));
         endcase
         steady = (phase_no == 2);
         goal   = beats_sent + 42;
         while (beats_sent < goal) begin
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_beat($urandom_range(255), $urandom_range(1), $urandom_range(1));
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  case ($urandom_range(9))
                     0, 1: begin
                        repeat ($urandom_range(1, 6))
                           run_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
                     end
                     2: begin
                        append_text("&");
                        repeat ($urandom_range(1, 5))
                           run_q.push_back(name_chars[$urandom_range(name_chars.len() - 1)]);
                        if ($urandom_range(9) != 0) append_text(";");
                     end
                     3: begin
                        append_text("&#");
                        repeat ($urandom_range(1, 4)) run_q.push_back(CH_DIGIT_0 + $urandom_range(9));
                        if ($urandom_range(9) != 0) append_text(";");
                     end
                     4: begin
                        append_text($urandom_range(1) ? "&#x" : "&#X");
                        repeat ($urandom_range(1, 4))
                           run_q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
                        if ($urandom_range(9) != 0) append_text(";");
                     end
                     5: begin
                        append_text("\\");
                        run_q.push_back(esc_tail[$urandom_range(esc_tail.len() - 1)]);
                     end
                     6: begin
                        append_text("@");
                        run_q.push_back($urandom_range(1) ? CH_LBRACE : CH_LOWER_A);
                     end
                     7: run_q.push_back(stops[$urandom_range(2)]);
                     8: run_q.push_back($urandom_range(255));
                     default: begin
                        append_text("&");
                        run_q.push_back($urandom_range(255));
                     end
                  endcase
               end
               send_run(1'b1, $urandom_range(9) < 7);
            end
         end
      end
      steady = 1'b0;
      settle();

      $display("tb: %0d text beats sent, %0d tokens checked, %0d register settings applied",
               beats_sent, tokens_checked, settings_applied);
      if (error_count == 0 && pending_tokens == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
